>>> rtl/core/vwb_pkg.sv
// Shared types and constants of the Verlet wall-bounce integrator.
package vwb_pkg;

    // Internal position width: wide enough for four damped bounces without wrap.
    localparam int W = 36;
    // Width of the damped product, position times unsigned Q1.15 damping.
    localparam int PW = W + 17;

    typedef logic signed [W-1:0]  t_pos;
    typedef logic signed [PW-1:0] t_prod;

    // Round-half-up offset for the Q.35 to Q.20 damping shift.
    localparam t_prod RND_DAMP = t_prod'(1) <<< 14;

    // One ball in flight through the wall stages.
    typedef struct packed {
        t_pos        cur_x;
        t_pos        cur_y;
        t_pos        prev_x;
        t_pos        prev_y;
        t_pos        ah_x;
        t_pos        ah_y;
        logic [20:0] radius;
        logic [3:0]  hits;
        logic        last;
    } t_ball;

    // Static description of one wall test.
    typedef struct packed {
        logic        axis_y;   // normal axis: 1 for y, 0 for x
        logic        dir_pos;  // bounce pushes toward +axis
        logic [22:0] limit;    // wall distance from origin, unsigned Q3.20
        logic [3:0]  mask;     // hit flag for this wall
    } t_wall_cfg;

endpackage

>>> rtl/core/vwb_wall.sv
// One wall test with damped bounce, three pipeline stages.
module vwb_wall import vwb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_wall_cfg  i_wall,
    input  logic [15:0] i_damp,
    input  logic       i_valid,
    input  t_ball      i_ball,
    output logic       o_valid,
    output t_ball      o_ball
);

    // stage A: hit test, displacement with forced normal sign
    logic  r_a_valid;
    t_ball r_a_ball;
    t_pos  r_a_wx, r_a_wy, r_a_wall;
    logic  r_a_hit;
    // stage B: damping products
    logic  r_b_valid;
    t_ball r_b_ball;
    t_prod r_b_px, r_b_py;
    t_pos  r_b_wall;
    logic  r_b_hit;
    // stage C: clamp and rebuild prev
    logic  r_c_valid;
    t_ball r_c_ball;

    t_pos  n_a_wall, n_a_wx, n_a_wy, a_c, a_wn, a_mag, a_forced, a_rad, a_lim;
    logic  n_a_hit;
    t_prod c_tx, c_ty;
    t_pos  c_wx, c_wy;
    t_ball n_c_ball;

    always_comb begin
        a_rad    = {{(W-21){1'b0}}, i_ball.radius};
        a_lim    = {{(W-23){1'b0}}, i_wall.limit};
        n_a_wall = i_wall.dir_pos ? (a_rad - a_lim) : (a_lim - a_rad);
        a_c      = i_wall.axis_y ? i_ball.cur_y : i_ball.cur_x;
        n_a_hit  = i_wall.dir_pos ? (a_c < n_a_wall) : (a_c > n_a_wall);
        n_a_wx   = i_ball.cur_x - i_ball.prev_x + i_ball.ah_x;
        n_a_wy   = i_ball.cur_y - i_ball.prev_y + i_ball.ah_y;
        a_wn     = i_wall.axis_y ? n_a_wy : n_a_wx;
        a_mag    = a_wn[W-1] ? -a_wn : a_wn;
        a_forced = i_wall.dir_pos ? a_mag : -a_mag;
        if (i_wall.axis_y) begin
            n_a_wy = a_forced;
        end else begin
            n_a_wx = a_forced;
        end
    end

    always_comb begin
        c_tx     = r_b_px + RND_DAMP;
        c_ty     = r_b_py + RND_DAMP;
        c_wx     = c_tx[W+14:15];
        c_wy     = c_ty[W+14:15];
        n_c_ball = r_b_ball;
        if (r_b_hit) begin
            if (i_wall.axis_y) begin
                n_c_ball.cur_y = r_b_wall;
            end else begin
                n_c_ball.cur_x = r_b_wall;
            end
            n_c_ball.prev_x = n_c_ball.cur_x - c_wx + r_b_ball.ah_x;
            n_c_ball.prev_y = n_c_ball.cur_y - c_wy + r_b_ball.ah_y;
            n_c_ball.hits   = r_b_ball.hits | i_wall.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ball <= i_ball;
            r_a_wx   <= n_a_wx;
            r_a_wy   <= n_a_wy;
            r_a_wall <= n_a_wall;
            r_a_hit  <= n_a_hit;
            r_b_ball <= r_a_ball;
            r_b_px   <= r_a_wx * $signed({1'b0, i_damp});
            r_b_py   <= r_a_wy * $signed({1'b0, i_damp});
            r_b_wall <= r_a_wall;
            r_b_hit  <= r_a_hit;
            r_c_ball <= n_c_ball;
        end
    end

    assign o_valid = r_c_valid;
    assign o_ball  = r_c_ball;

endmodule

>>> rtl/core/verlet_integrate_wall_bounce.sv
// Top level of the fixed-point Verlet integrator with wall bounce.
// Takes one ball per cycle on the slave stream while the skid entry is empty,
// and returns one updated ball per transaction on the master stream, in order.
// Fifteen register stages sit between the two streams: one for the acc*dt^2
// multiplier, one for rounding and the Verlet step, three for each of the four
// walls (test, damping multiply, clamp and rebuild) and the output register.
// Sustained rate is one ball per cycle while the master side does not stall.
// When the master side stalls with a result waiting in the output register,
// the next result spills into a one-entry skid behind it; the whole pipeline
// and the slave side then hold until the skid entry drains, which happens at
// the end of the first cycle with m_axis_tready high.
// Walls are tested floor, ceiling, right, left; each test sees the state the
// earlier ones left. Registers sit on an APB port: dt_squared at 0x0,
// bounce_damping at 0x4, half_width at 0x8. Write them only while idle.
module verlet_integrate_wall_bounce import vwb_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata, low bit up: cur_x[23:0], cur_y[47:24], prev_x[71:48], prev_y[95:72],
    // acc_x[119:96], acc_y[143:120], radius[164:144], zero pad[167:165]
    input  logic [167:0] s_axis_tdata,
    input  logic         s_axis_tlast,     // last_ball
    // master stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata, low bit up: new_cur_x[23:0], new_cur_y[47:24], new_prev_x[71:48],
    // new_prev_y[95:72], walls_hit[99:96], zero pad[103:100]
    output logic [103:0] m_axis_tdata,
    output logic         m_axis_tlast,     // is_last
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [1:0] REG_DT_SQ   = 2'd0;
    localparam logic [1:0] REG_DAMP    = 2'd1;
    localparam logic [1:0] REG_HALF_W  = 2'd2;

    localparam logic [1:0] WALL_FLOOR  = 2'd0;
    localparam logic [1:0] WALL_CEIL   = 2'd1;
    localparam logic [1:0] WALL_RIGHT  = 2'd2;
    localparam logic [1:0] WALL_LEFT   = 2'd3;

    localparam logic [22:0] ONE_Q20    = 23'h100000;

    localparam logic signed [56:0] RND_AF = 57'sd1 <<< 27;
    localparam logic signed [56:0] RND_AH = 57'sd1 <<< 28;

    function automatic t_wall_cfg f_wall_cfg(input logic [1:0] idx, input logic [22:0] hw);
        t_wall_cfg c;
        unique case (idx)
            WALL_FLOOR: c = '{axis_y: 1'b1, dir_pos: 1'b1, limit: ONE_Q20, mask: 4'b0001};
            WALL_CEIL:  c = '{axis_y: 1'b1, dir_pos: 1'b0, limit: ONE_Q20, mask: 4'b0010};
            WALL_RIGHT: c = '{axis_y: 1'b0, dir_pos: 1'b0, limit: hw,      mask: 4'b0100};
            WALL_LEFT:  c = '{axis_y: 1'b0, dir_pos: 1'b1, limit: hw,      mask: 4'b1000};
            default:    c = '{axis_y: 1'b0, dir_pos: 1'b1, limit: hw,      mask: 4'b1000};
        endcase
        return c;
    endfunction

    function automatic logic [23:0] f_sat24(input t_pos v);
        logic [23:0] r;
        if (v > t_pos'(8388607)) begin
            r = 24'h7FFFFF;
        end else if (v < t_pos'(-8388608)) begin
            r = 24'h800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- config
    logic [31:0] r_dt_sq;
    logic [15:0] r_damp;
    logic [22:0] r_half_w;

    assign pready = 1'b1;

    // Take a register write in the APB access phase; ignore unmapped indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt_sq  <= 32'd18641;
            r_damp   <= 16'd32768;
            r_half_w <= 23'd1048576;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_DT_SQ:  r_dt_sq  <= pwdata;
                REG_DAMP:   r_damp   <= pwdata[15:0];
                REG_HALF_W: r_half_w <= pwdata[22:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DT_SQ:  prdata = r_dt_sq;
            REG_DAMP:   prdata = {16'd0, r_damp};
            REG_HALF_W: prdata = {9'd0, r_half_w};
            default:    prdata = 32'd0;
        endcase
    end

    // -------------------------------------------------------------- pipeline
    // The whole pipeline advances together; freeze it only while the skid
    // entry holds a result, so no transaction is lost or repeated.
    logic r_skid_valid;
    logic en;

    assign en            = !r_skid_valid;
    assign s_axis_tready = en;

    // Stage 1: acceleration times dt^2 (Q8.16 x Q0.32 = Q.48).
    logic                    r_s1_valid;
    logic signed [56:0]      r_s1_px, r_s1_py;
    logic signed [23:0]      r_s1_cur_x, r_s1_cur_y, r_s1_prev_x, r_s1_prev_y;
    logic [20:0]             r_s1_radius;
    logic                    r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_px     <= $signed(s_axis_tdata[119:96]) * $signed({1'b0, r_dt_sq});
            r_s1_py     <= $signed(s_axis_tdata[143:120]) * $signed({1'b0, r_dt_sq});
            r_s1_cur_x  <= s_axis_tdata[23:0];
            r_s1_cur_y  <= s_axis_tdata[47:24];
            r_s1_prev_x <= s_axis_tdata[71:48];
            r_s1_prev_y <= s_axis_tdata[95:72];
            r_s1_radius <= s_axis_tdata[164:144];
            r_s1_last   <= s_axis_tlast;
        end
    end

    // Stage 2: round the step and half-step terms to Q.20, do the Verlet step.
    logic signed [56:0] s2_afx_t, s2_afy_t, s2_ahx_t, s2_ahy_t;
    t_pos  s2_afx, s2_afy, s2_cx, s2_cy;
    t_ball n_s2_ball;
    logic  r_s2_valid;
    t_ball r_s2_ball;

    always_comb begin
        s2_afx_t = r_s1_px + RND_AF;
        s2_afy_t = r_s1_py + RND_AF;
        s2_ahx_t = r_s1_px + RND_AH;
        s2_ahy_t = r_s1_py + RND_AH;
        s2_afx   = {{(W-29){s2_afx_t[56]}}, s2_afx_t[56:28]};
        s2_afy   = {{(W-29){s2_afy_t[56]}}, s2_afy_t[56:28]};
        s2_cx    = t_pos'(r_s1_cur_x);
        s2_cy    = t_pos'(r_s1_cur_y);
        n_s2_ball.cur_x  = (s2_cx <<< 1) - t_pos'(r_s1_prev_x) + s2_afx;
        n_s2_ball.cur_y  = (s2_cy <<< 1) - t_pos'(r_s1_prev_y) + s2_afy;
        n_s2_ball.prev_x = s2_cx;
        n_s2_ball.prev_y = s2_cy;
        n_s2_ball.ah_x   = {{(W-28){s2_ahx_t[56]}}, s2_ahx_t[56:29]};
        n_s2_ball.ah_y   = {{(W-28){s2_ahy_t[56]}}, s2_ahy_t[56:29]};
        n_s2_ball.radius = r_s1_radius;
        n_s2_ball.hits   = 4'd0;
        n_s2_ball.last   = r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_ball <= n_s2_ball;
        end
    end

    // Stages 3 to 14: floor, ceiling, right and left walls in turn.
    logic  wl_valid [5];
    t_ball wl_ball  [5];

    assign wl_valid[0] = r_s2_valid;
    assign wl_ball[0]  = r_s2_ball;

    for (genvar g = 0; g < 4; g++) begin : g_wall
        vwb_wall u_wall (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_wall  (f_wall_cfg(2'(g), r_half_w)),
            .i_damp  (r_damp),
            .i_valid (wl_valid[g]),
            .i_ball  (wl_ball[g]),
            .o_valid (wl_valid[g+1]),
            .o_ball  (wl_ball[g+1])
        );
    end

    // ---------------------------------------------------------- output side
    // Saturate to Q4.20 and pack; hold in the output register, spill into
    // the skid entry when the master side stalls.
    logic [103:0] res_data;
    logic         emit;
    logic         r_out_valid;
    logic [103:0] r_out_data;
    logic         r_out_last;
    logic [103:0] r_skid_data;
    logic         r_skid_last;

    assign res_data = {4'd0, wl_ball[4].hits,
                       f_sat24(wl_ball[4].prev_y), f_sat24(wl_ball[4].prev_x),
                       f_sat24(wl_ball[4].cur_y),  f_sat24(wl_ball[4].cur_x)};
    assign emit     = en && wl_valid[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // drain the skid entry once the output register frees up
            if (!r_out_valid || m_axis_tready) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (emit) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out_data <= r_skid_data;
                r_out_last <= r_skid_last;
            end
        end else if (emit) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out_data <= res_data;
                r_out_last <= wl_ball[4].last;
            end else begin
                r_skid_data <= res_data;
                r_skid_last <= wl_ball[4].last;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

>>> tb/testbench.sv
// Self-checking stream testbench for the Verlet wall-bounce integrator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Register byte addresses on the APB port.
    localparam logic [3:0] ADDR_DT_SQ  = 4'h0;
    localparam logic [3:0] ADDR_DAMP   = 4'h4;
    localparam logic [3:0] ADDR_HALF_W = 4'h8;
    localparam logic [3:0] ADDR_SPARE  = 4'hC;  // no register here, writes drop

    // Bit positions in walls_hit, also the order in which walls are tested.
    localparam int FLOOR_BIT = 0;
    localparam int CEIL_BIT  = 1;
    localparam int RIGHT_BIT = 2;
    localparam int LEFT_BIT  = 3;

    localparam longint ONE_Q20 = 1048576;
    localparam longint OUT_MAX = 8388607;
    localparam longint OUT_MIN = -8388608;

    localparam int NUM_PHASES     = 9;
    localparam int BALLS_PER_PHASE = 200;

    // One ball as it enters the block.
    typedef struct packed {
        logic signed [23:0] cur_x;
        logic signed [23:0] cur_y;
        logic signed [23:0] prev_x;
        logic signed [23:0] prev_y;
        logic signed [23:0] acc_x;
        logic signed [23:0] acc_y;
        logic [20:0]        radius;
        logic               last;
    } ball_in_t;

    // One updated ball as it leaves the block.
    typedef struct packed {
        logic [23:0] cur_x;
        logic [23:0] cur_y;
        logic [23:0] prev_x;
        logic [23:0] prev_y;
        logic [3:0]  hits;
        logic        last;
    } ball_out_t;

    // Directed stimulus row; want is used only where typed is set.
    typedef struct packed {
        ball_in_t  ball;
        logic      typed;
        ball_out_t want;
    } ball_row_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    // Shadow copies of the block's registers, at reset values.
    logic [31:0]  dt_sq_cfg  = 32'd18641;
    logic [15:0]  damp_cfg   = 16'd32768;
    logic [22:0]  half_w_cfg = 23'd1048576;

    ball_out_t    pending_balls[$];   // updated balls still owed by the block
    ball_row_t    ball_table[$];
    int           err_count = 0;
    bit           tx_calm = 1'b0;
    bit           rx_calm = 1'b0;
    int           rx_hold = 0;
    int           rx_cycle = 0;

    verlet_integrate_wall_bounce u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Round half up, then floor shift right by s.
    function automatic longint round_shift(input longint p, input int s);
        return (p + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [23:0] clip24(input longint v);
        if (v > OUT_MAX) v = OUT_MAX;
        else if (v < OUT_MIN) v = OUT_MIN;
        return v[23:0];
    endfunction

    // Advance one ball by a Verlet step, then bounce it off the four walls.
    function automatic ball_out_t predict_ball(input ball_in_t b);
        longint    pc [2];
        longint    pp [2];
        longint    af [2];
        longint    ah [2];
        longint    w [2];
        longint    acc, prod, nxt, r, hw, wall;
        int        axis;
        bit        hit, push_pos;
        ball_out_t o;
        o = '0;
        r = b.radius;
        hw = half_w_cfg;
        pc[0] = $signed(b.cur_x);
        pc[1] = $signed(b.cur_y);
        pp[0] = $signed(b.prev_x);
        pp[1] = $signed(b.prev_y);
        for (int k = 0; k < 2; k++) begin
            acc = (k == 0) ? $signed(b.acc_x) : $signed(b.acc_y);
            prod = acc * longint'(dt_sq_cfg);
            af[k] = round_shift(prod, 28);
            ah[k] = round_shift(prod, 29);
        end
        for (int k = 0; k < 2; k++) begin
            nxt = 2 * pc[k] - pp[k] + af[k];
            pp[k] = pc[k];
            pc[k] = nxt;
        end
        // Each wall sees the state the earlier walls left behind.
        for (int wi = 0; wi < 4; wi++) begin
            case (wi)
                FLOOR_BIT: begin
                    axis = 1; push_pos = 1'b1; wall = r - ONE_Q20;
                    hit = (pc[1] - r < -ONE_Q20);
                end
                CEIL_BIT: begin
                    axis = 1; push_pos = 1'b0; wall = ONE_Q20 - r;
                    hit = (pc[1] + r > ONE_Q20);
                end
                RIGHT_BIT: begin
                    axis = 0; push_pos = 1'b0; wall = hw - r;
                    hit = (pc[0] + r > hw);
                end
                default: begin
                    axis = 0; push_pos = 1'b1; wall = r - hw;
                    hit = (pc[0] - r < -hw);
                end
            endcase
            if (hit) begin
                for (int k = 0; k < 2; k++) w[k] = (pc[k] - pp[k]) + ah[k];
                if (push_pos) w[axis] = (w[axis] < 0) ? -w[axis] : w[axis];
                else w[axis] = (w[axis] > 0) ? -w[axis] : w[axis];
                for (int k = 0; k < 2; k++) w[k] = round_shift(w[k] * longint'(damp_cfg), 15);
                pc[axis] = wall;
                for (int k = 0; k < 2; k++) pp[k] = pc[k] - w[k] + ah[k];
                o.hits[wi] = 1'b1;
            end
        end
        o.cur_x  = clip24(pc[0]);
        o.cur_y  = clip24(pc[1]);
        o.prev_x = clip24(pp[0]);
        o.prev_y = clip24(pp[1]);
        o.last   = b.last;
        return o;
    endfunction

    function automatic ball_in_t mk_ball(input logic [23:0] cx, input logic [23:0] cy,
                                         input logic [23:0] px, input logic [23:0] py,
                                         input logic [23:0] ax, input logic [23:0] ay,
                                         input logic [20:0] r, input logic lst);
        ball_in_t b;
        b.cur_x = cx; b.cur_y = cy; b.prev_x = px; b.prev_y = py;
        b.acc_x = ax; b.acc_y = ay; b.radius = r; b.last = lst;
        return b;
    endfunction

    function automatic ball_out_t mk_out(input logic [23:0] cx, input logic [23:0] cy,
                                         input logic [23:0] px, input logic [23:0] py,
                                         input logic [3:0] hits, input logic lst);
        ball_out_t o;
        o.cur_x = cx; o.cur_y = cy; o.prev_x = px; o.prev_y = py;
        o.hits = hits; o.last = lst;
        return o;
    endfunction

    function automatic void add_row(input ball_in_t b, input logic typed, input ball_out_t want);
        ball_row_t row;
        row.ball = b; row.typed = typed; row.want = want;
        ball_table.push_back(row);
    endfunction

    // Mostly back-to-back, sometimes a few cycles, rarely a long stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Uniform value in [-span, span], wrapped to 24 bits.
    function automatic logic [23:0] spread(input int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span;
        return v[23:0];
    endfunction

    function automatic logic [23:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'h000000;
            3: return 24'hFFFFFF;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic ball_in_t rand_ball();
        ball_in_t b;
        int       kind;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            // raw noise over the full field ranges
            b.cur_x = 24'($urandom()); b.cur_y = 24'($urandom());
            b.prev_x = 24'($urandom()); b.prev_y = 24'($urandom());
            b.acc_x = 24'($urandom()); b.acc_y = 24'($urandom());
            b.radius = 21'($urandom_range(0, 21'h1FFFFF));
        end else if (kind < 9) begin
            // plausible ball near the box, small velocity and acceleration
            b.cur_x = spread(24'h180000);
            b.cur_y = spread(24'h180000);
            b.prev_x = b.cur_x + spread(($urandom_range(0, 3) == 0) ? 24'h80000 : 24'h8000);
            b.prev_y = b.cur_y + spread(($urandom_range(0, 3) == 0) ? 24'h80000 : 24'h8000);
            b.acc_x = spread(($urandom_range(0, 3) == 0) ? 24'h7FFFFF : 24'h40000);
            b.acc_y = spread(($urandom_range(0, 3) == 0) ? 24'h7FFFFF : 24'h40000);
            b.radius = ($urandom_range(0, 7) == 0) ? 21'($urandom_range(0, 21'h1FFFFF))
                                                   : 21'($urandom_range(0, 21'h40000));
        end else begin
            b.cur_x = pick_extreme(); b.cur_y = pick_extreme();
            b.prev_x = pick_extreme(); b.prev_y = pick_extreme();
            b.acc_x = pick_extreme(); b.acc_y = pick_extreme();
            case ($urandom_range(0, 3))
                0: b.radius = 21'h000000;
                1: b.radius = 21'h100000;
                2: b.radius = 21'h1FFFFF;
                default: b.radius = 21'($urandom_range(0, 21'h1FFFFF));
            endcase
        end
        b.last = ($urandom_range(0, 7) == 0);
        return b;
    endfunction

    // APB write: setup cycle, access cycle, then an idle cycle.
    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (addr)
            ADDR_DT_SQ:  dt_sq_cfg  = data;
            ADDR_DAMP:   damp_cfg   = data[15:0];
            ADDR_HALF_W: half_w_cfg = data[22:0];
            default: ;
        endcase
        psel <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(input logic [3:0] addr);
        logic [31:0] want;
        case (addr)
            ADDR_DT_SQ: want = dt_sq_cfg;
            ADDR_DAMP:  want = {16'h0, damp_cfg};
            default:    want = {9'h0, half_w_cfg};
        endcase
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $display("%0t: register %h expected %h got %h", $realtime, addr, want, prdata);
            err_count++;
        end
        psel <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_regs();
        apb_read_check(ADDR_DT_SQ);
        apb_read_check(ADDR_DAMP);
        apb_read_check(ADDR_HALF_W);
    endtask

    task automatic program_regs(input logic [31:0] dt, input logic [31:0] damp,
                                input logic [31:0] hw);
        apb_write(ADDR_DT_SQ, dt);
        apb_write(ADDR_DAMP, damp);
        apb_write(ADDR_HALF_W, hw);
        check_regs();
    endtask

    // Offer one ball, hold it until the transaction, then maybe drop valid for a while.
    task automatic send_ball(input ball_in_t b, input ball_out_t want, input bit calm);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, b.radius, b.acc_y, b.acc_x,
                          b.prev_y, b.prev_x, b.cur_y, b.cur_x};
        s_axis_tlast  <= b.last;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_balls.push_back(want);
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold until every owed ball has come back, waiting on the clock before the first check.
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_balls.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_field(input string name, input logic [23:0] want,
                                input logic [23:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $realtime, name, want, got);
            err_count++;
        end
    endtask

    // Receiver backpressure: random stalls, with calm stretches of full rate.
    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 200 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            rx_hold = rx_calm ? 0 : pick_gap();
            m_axis_tready <= (rx_hold == 0);
            if (rx_hold > 0) rx_hold--;
        end
    end

    // Compare each output transaction with the oldest owed ball.
    always @(posedge i_clk) begin
        ball_out_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.cur_x  = m_axis_tdata[23:0];
            got.cur_y  = m_axis_tdata[47:24];
            got.prev_x = m_axis_tdata[71:48];
            got.prev_y = m_axis_tdata[95:72];
            got.hits   = m_axis_tdata[99:96];
            got.last   = m_axis_tlast;
            if (pending_balls.size() == 0) begin
                $display("%0t: unexpected result, cur %h %h prev %h %h hits %h",
                         $realtime, got.cur_x, got.cur_y, got.prev_x, got.prev_y, got.hits);
                err_count++;
            end else begin
                want = pending_balls.pop_front();
                report_field("new_cur_x", want.cur_x, got.cur_x);
                report_field("new_cur_y", want.cur_y, got.cur_y);
                report_field("new_prev_x", want.prev_x, got.prev_x);
                report_field("new_prev_y", want.prev_y, got.prev_y);
                report_field("walls_hit", 24'(want.hits), 24'(got.hits));
                report_field("is_last", 24'(want.last), 24'(got.last));
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #(10_000_000);
        $display("tb: failure");
        $finish;
    end

    initial begin
        ball_in_t  b;
        ball_row_t row;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_regs();

        // Directed table under reset settings: dt^2 18641, damping 1.0, half width 1.0.
        // at rest at the origin
        add_row(mk_ball(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 21'h0, 1'b0), 1'b1,
                mk_out(24'h0, 24'h0, 24'h0, 24'h0, 4'h0, 1'b0));
        // at rest at (0.25, 0.25), end of pass
        add_row(mk_ball(24'h040000, 24'h040000, 24'h040000, 24'h040000, 24'h0, 24'h0,
                        21'h0, 1'b1), 1'b1,
                mk_out(24'h040000, 24'h040000, 24'h040000, 24'h040000, 4'h0, 1'b1));
        // radius exactly 1.0 touches all walls without crossing
        add_row(mk_ball(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 21'h100000, 1'b0), 1'b1,
                mk_out(24'h0, 24'h0, 24'h0, 24'h0, 4'h0, 1'b0));
        // point ball resting on the right wall
        add_row(mk_ball(24'h100000, 24'h0, 24'h100000, 24'h0, 24'h0, 24'h0, 21'h0, 1'b0), 1'b1,
                mk_out(24'h100000, 24'h0, 24'h100000, 24'h0, 4'h0, 1'b0));
        // radius just above 1.0 crosses all four walls
        add_row(mk_ball(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 21'h100001, 1'b0), 1'b0, '0);
        // out-of-range radius, moving ball
        add_row(mk_ball(24'h010000, 24'hFF0000, 24'h0, 24'h0, 24'h012345, 24'hFEDCBA,
                        21'h1FFFFF, 1'b1), 1'b0, '0);
        // floor, ceiling, right, left and a corner
        add_row(mk_ball(24'h0, 24'hF10000, 24'h001000, 24'hF20000, 24'h0, 24'hF60000,
                        21'h020000, 1'b0), 1'b0, '0);
        add_row(mk_ball(24'h0, 24'h0F0000, 24'h0, 24'h0E0000, 24'h0, 24'h0A0000,
                        21'h020000, 1'b0), 1'b0, '0);
        add_row(mk_ball(24'h0F8000, 24'h0, 24'h0F0000, 24'h0, 24'h0, 24'h0,
                        21'h010000, 1'b0), 1'b0, '0);
        add_row(mk_ball(24'hF08000, 24'h0, 24'hF10000, 24'h0, 24'h0, 24'h0,
                        21'h010000, 1'b0), 1'b0, '0);
        add_row(mk_ball(24'hF08000, 24'hF10000, 24'hF10000, 24'hF18000, 24'h0, 24'h0,
                        21'h020000, 1'b0), 1'b0, '0);
        // field extremes, with saturation on the way out
        add_row(mk_ball(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                        24'h7FFFFF, 21'h1FFFFF, 1'b1), 1'b0, '0);
        add_row(mk_ball(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
                        24'h800000, 21'h0, 1'b0), 1'b0, '0);
        add_row(mk_ball(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h0, 24'h0,
                        21'h0, 1'b0), 1'b0, '0);
        add_row(mk_ball(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h0, 24'h0,
                        21'h0, 1'b0), 1'b0, '0);
        add_row(mk_ball(24'h0, 24'h0, 24'h0, 24'h0, 24'h7FFFFF, 24'h7FFFFF, 21'h0, 1'b0),
                1'b0, '0);
        add_row(mk_ball(24'h0, 24'h0, 24'h0, 24'h0, 24'h800000, 24'h800000, 21'h0, 1'b0),
                1'b0, '0);
        // alternating bit patterns
        add_row(mk_ball(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
                        24'h555555, 21'h0AAAAA, 1'b1), 1'b0, '0);
        add_row(mk_ball(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555,
                        24'hAAAAAA, 21'h155555, 1'b0), 1'b0, '0);

        foreach (ball_table[i]) begin
            row = ball_table[i];
            send_ball(row.ball, row.typed ? row.want : predict_ball(row.ball), 1'b0);
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: program_regs(32'd18641, 32'd32768, 32'd1048576);
                1: begin
                    // all ones: masked to each width, damping near 2.0
                    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                    apb_write(ADDR_SPARE, $urandom());
                    check_regs();
                end
                2: program_regs(32'd0, 32'd0, 32'd0);
                3: program_regs(32'd0, 32'd32768, 32'h007F_FFFF);
                default: program_regs(
                    ($urandom_range(0, 1) == 1) ? $urandom_range(0, 1 << 22) : $urandom(),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(32769, 65535)
                                                : $urandom_range(0, 32768),
                    ($urandom_range(0, 1) == 1) ? $urandom_range(24'h80000, 24'h180000)
                                                : $urandom_range(0, 24'h7FFFFF));
            endcase
            for (int n = 0; n < BALLS_PER_PHASE; n++) begin
                if (n % 50 == 0) tx_calm = ($urandom_range(0, 4) == 0);
                if (ph == 3 && n == BALLS_PER_PHASE / 2) begin
                    // starve the input until the pipeline has fully emptied
                    s_axis_tvalid <= 1'b0;
                    wait_drained();
                end
                b = rand_ball();
                send_ball(b, predict_ball(b), tx_calm);
            end
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (pending_balls.size() != 0) begin
            $display("%0t: %0d results never arrived", $realtime, pending_balls.size());
            err_count++;
        end
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
